/* design/btm_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package btm_pkg;

    localparam int unsigned PIX_W        = 8;
    localparam int unsigned COORD_W      = 10;
    localparam int unsigned THR_W        = 9;
    localparam int unsigned DIM_W        = 11;
    localparam int unsigned CFG_IDX_W    = 2;
    localparam int unsigned CFG_DATA_W   = 11;
    localparam int unsigned WIN_W        = 9;

    localparam int unsigned MAX_WIDTH_DEF = 1024;
    localparam int unsigned MAX_HEIGHT    = 1024;
    localparam int unsigned DIM_MIN       = 3;

    localparam logic [THR_W-1:0] THR_RESET    = 9'd30;
    localparam logic [DIM_W-1:0] WIDTH_RESET  = 11'd640;
    localparam logic [DIM_W-1:0] HEIGHT_RESET = 11'd480;

    localparam logic [PIX_W-1:0] FG_VALUE = 8'd255;
    localparam logic [PIX_W-1:0] BG_VALUE = 8'd0;
    localparam logic [WIN_W-1:0] WIN_FULL = 9'h1FF;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_THRESHOLD = 2'd0,
        CFG_MODE      = 2'd1,
        CFG_WIDTH     = 2'd2,
        CFG_HEIGHT    = 2'd3
    } t_cfg_index;

    typedef enum logic {
        MODE_ERODE  = 1'b0,
        MODE_DILATE = 1'b1
    } t_mode;

    // control from the pixel pipeline to the line stores
    // wr_bits[1] goes to the middle row store, wr_bits[0] to the upper row store
    typedef struct packed {
        logic       rd_en;
        logic       wr_en;
        logic [1:0] wr_bits;
    } t_ls_ctrl;

endpackage

`default_nettype wire

/* design/btm_pix_if.sv */
`timescale 1ns / 1ps
`default_nettype none

interface btm_pix_if;
    import btm_pkg::*;

    logic             valid;
    logic             ready;
    logic [PIX_W-1:0] pixel_in;

    modport source (output valid, output pixel_in, input ready);
    modport sink   (input valid, input pixel_in, output ready);
endinterface

`default_nettype wire

/* design/btm_res_if.sv */
`timescale 1ns / 1ps
`default_nettype none

interface btm_res_if;
    import btm_pkg::*;

    logic               valid;
    logic               ready;
    logic [PIX_W-1:0]   pixel_out;
    logic [COORD_W-1:0] out_row;
    logic [COORD_W-1:0] out_col;

    modport source (output valid, output pixel_out, output out_row, output out_col,
                    input ready);
    modport sink   (input valid, input pixel_out, input out_row, input out_col,
                    output ready);
endinterface

`default_nettype wire

/* design/btm_cfg_if.sv */
`timescale 1ns / 1ps
`default_nettype none

interface btm_cfg_if;
    import btm_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

/* design/btm_line_store.sv */
`timescale 1ns / 1ps
`default_nettype none

module btm_line_store #(
    parameter int unsigned DEPTH = btm_pkg::MAX_WIDTH_DEF
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire btm_pkg::t_ls_ctrl        i_ctrl,
    input  wire logic [$clog2(DEPTH)-1:0] i_rd_addr,
    input  wire logic [$clog2(DEPTH)-1:0] i_wr_addr,
    output logic [1:0]                    o_rd_bits,
    output logic                          o_busy
);
    import btm_pkg::*;

    localparam int unsigned ADDR_W = $clog2(DEPTH);
    localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(DEPTH - 1);

    // upper and middle row stores share the column address, so they sit side by side
    logic [1:0] mem [DEPTH];

    logic              r_clr_busy;
    logic [ADDR_W-1:0] r_clr_addr;
    logic [1:0]        r_rd_bits;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_busy <= 1'b1;
            r_clr_addr <= '0;
        end else if (r_clr_busy) begin
            if (r_clr_addr == LAST_ADDR) begin
                r_clr_busy <= 1'b0;
            end
            r_clr_addr <= r_clr_addr + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_clr_busy) begin
            mem[r_clr_addr] <= 2'b00;
        end else if (i_ctrl.wr_en) begin
            mem[i_wr_addr] <= i_ctrl.wr_bits;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.rd_en) begin
            r_rd_bits <= mem[i_rd_addr];
        end
    end

    assign o_rd_bits = r_rd_bits;
    assign o_busy    = r_clr_busy;

endmodule

`default_nettype wire

/* design/binary_threshold_morphology_3x3_top.sv */
`timescale 1ns / 1ps
`default_nettype none

// channel   dir  modport  payload                          transaction
// i_pix     in   sink     pixel_in[7:0]                    valid & ready
// o_res     out  source   pixel_out[7:0] out_row out_col   valid & ready
// i_cfg     in   sink     index[1:0] data[10:0]            valid & ready, ready always high
//
// one pixel per clock while results are taken; a result passes the line store
// read, then the window update into the result register
// after reset the line stores are cleared one column a cycle, all MAX_WIDTH columns,
// and no pixel is taken during that sweep
// a stalled result holds the pipeline; a new pixel is still taken when the
// result register is about to be emptied in the same cycle

module binary_threshold_morphology_3x3_top #(
    parameter int unsigned MAX_WIDTH = btm_pkg::MAX_WIDTH_DEF
) (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    btm_pix_if.sink      i_pix,
    btm_res_if.source    o_res,
    btm_cfg_if.sink      i_cfg
);
    import btm_pkg::*;

    localparam int unsigned ADDR_W = $clog2(MAX_WIDTH);
    localparam int unsigned WW     = ($clog2(MAX_WIDTH + 1) > DIM_W) ?
                                     $clog2(MAX_WIDTH + 1) : DIM_W;

    // configuration
    logic [THR_W-1:0] r_threshold;
    t_mode            r_mode;
    logic [DIM_W-1:0] r_frame_width;
    logic [DIM_W-1:0] r_frame_height;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_threshold    <= THR_RESET;
            r_mode         <= MODE_ERODE;
            r_frame_width  <= WIDTH_RESET;
            r_frame_height <= HEIGHT_RESET;
        end else if (i_cfg.valid) begin
            case (t_cfg_index'(i_cfg.index))
                CFG_THRESHOLD: r_threshold    <= i_cfg.data[THR_W-1:0];
                CFG_MODE:      r_mode         <= t_mode'(i_cfg.data[0]);
                CFG_WIDTH:     r_frame_width  <= i_cfg.data[DIM_W-1:0];
                CFG_HEIGHT:    r_frame_height <= i_cfg.data[DIM_W-1:0];
                default: ;
            endcase
        end
    end

    assign i_cfg.ready = 1'b1;

    // clamped frame size
    logic [WW-1:0]    width_lim;
    logic [DIM_W-1:0] height_lim;

    always_comb begin
        if (WW'(r_frame_width) < WW'(DIM_MIN)) begin
            width_lim = WW'(DIM_MIN);
        end else if (WW'(r_frame_width) > WW'(MAX_WIDTH)) begin
            width_lim = WW'(MAX_WIDTH);
        end else begin
            width_lim = WW'(r_frame_width);
        end
        if (r_frame_height < DIM_W'(DIM_MIN)) begin
            height_lim = DIM_W'(DIM_MIN);
        end else if (r_frame_height > DIM_W'(MAX_HEIGHT)) begin
            height_lim = DIM_W'(MAX_HEIGHT);
        end else begin
            height_lim = r_frame_height;
        end
    end

    // handshake and pipeline control
    logic ls_busy;
    logic pix_accept;
    logic a_adv;

    logic               r_a_valid;
    logic               r_a_bin;
    logic               r_a_emit;
    logic [COORD_W-1:0] r_a_row;
    logic [COORD_W-1:0] r_a_col;
    logic [ADDR_W-1:0]  r_a_addr;

    logic               r_o_valid;
    logic [PIX_W-1:0]   r_o_pixel;
    logic [COORD_W-1:0] r_o_row;
    logic [COORD_W-1:0] r_o_col;

    assign a_adv       = r_a_valid && (!r_o_valid || o_res.ready);
    assign i_pix.ready = !ls_busy && (!r_a_valid || a_adv);
    assign pix_accept  = i_pix.valid && i_pix.ready;

    // raster position of the next pixel
    logic [COORD_W-1:0] r_col;
    logic [COORD_W-1:0] r_row;
    logic [COORD_W:0]   col_inc;
    logic [COORD_W:0]   row_inc;

    assign col_inc = {1'b0, r_col} + 1'b1;
    assign row_inc = {1'b0, r_row} + 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else if (pix_accept) begin
            // at or past the limit wraps, so a smaller size takes effect at once
            if (WW'(col_inc) >= width_lim) begin
                r_col <= '0;
                if (DIM_W'(row_inc) >= height_lim) begin
                    r_row <= '0;
                end else begin
                    r_row <= row_inc[COORD_W-1:0];
                end
            end else begin
                r_col <= col_inc[COORD_W-1:0];
            end
        end
    end

    // stage a: line store read in flight
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else if (pix_accept) begin
            r_a_valid <= 1'b1;
        end else if (a_adv) begin
            r_a_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (pix_accept) begin
            r_a_bin  <= {1'b0, i_pix.pixel_in} >= r_threshold;
            r_a_emit <= (r_row != '0) && (r_col != '0);
            r_a_row  <= r_row;
            r_a_col  <= r_col;
            r_a_addr <= ADDR_W'(r_col);
        end
    end

    t_ls_ctrl   ls_ctrl;
    logic [1:0] ls_rd_bits;

    assign ls_ctrl.rd_en   = pix_accept;
    assign ls_ctrl.wr_en   = a_adv;
    // middle row moves up, new binary pixel becomes the middle row
    assign ls_ctrl.wr_bits = {r_a_bin, ls_rd_bits[1]};

    btm_line_store #(
        .DEPTH (MAX_WIDTH)
    ) u_line_store (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ctrl    (ls_ctrl),
        .i_rd_addr (ADDR_W'(r_col)),
        .i_wr_addr (r_a_addr),
        .o_rd_bits (ls_rd_bits),
        .o_busy    (ls_busy)
    );

    // window shift: bit row*3+col, col 2 newest
    logic [WIN_W-1:0] r_window;
    logic [WIN_W-1:0] n_window;
    logic [2:0]       col_bits;
    logic             win_set;
    logic             border;

    assign col_bits = {r_a_bin, ls_rd_bits[1], ls_rd_bits[0]};

    always_comb begin
        for (int row = 0; row < 3; row++) begin
            n_window[row*3 +: 3] = {col_bits[row], r_window[row*3+2], r_window[row*3+1]};
        end
    end

    assign win_set = (r_mode == MODE_ERODE) ? (n_window == WIN_FULL) : (n_window != '0);
    // centre in row 0 or column 0
    assign border  = (r_a_row < COORD_W'(2)) || (r_a_col < COORD_W'(2));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window  <= '0;
            r_o_valid <= 1'b0;
        end else if (a_adv) begin
            r_window  <= n_window;
            r_o_valid <= r_a_emit;
        end else if (o_res.ready) begin
            r_o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (a_adv) begin
            r_o_pixel <= (win_set && !border) ? FG_VALUE : BG_VALUE;
            r_o_row   <= r_a_row - 1'b1;
            r_o_col   <= r_a_col - 1'b1;
        end
    end

    assign o_res.valid     = r_o_valid;
    assign o_res.pixel_out = r_o_pixel;
    assign o_res.out_row   = r_o_row;
    assign o_res.out_col   = r_o_col;

`ifndef SYNTH
    a_no_pixel_while_clearing: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ls_busy |-> !i_pix.ready)
        else $error("pixel ready during line store clear");

    a_binary_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_o_valid |-> (r_o_pixel == FG_VALUE || r_o_pixel == BG_VALUE))
        else $error("result is not binary");

    a_border_is_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_o_valid && r_o_pixel != BG_VALUE) |-> (r_o_row != '0 && r_o_col != '0))
        else $error("border centre set");

    a_stage_a_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_a_valid && !a_adv) |=> (r_a_valid && $stable(r_a_addr) && $stable(r_a_bin)))
        else $error("stalled pixel lost in stage a");
`endif

endmodule

`default_nettype wire
